FILE: rtl/trs_pkg.sv
// Package for the triangle span rasterizer.
// Command codes and the controller/datapath interface structs; no dependencies.
`default_nettype none

package trs_pkg;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_SPAN = 1'b1;

   typedef struct packed {
      logic load;
      logic capture;
      logic init;
      logic step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic active;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: rtl/trs_divider.sv
// Restoring unsigned divider, one quotient bit per step.
// Generic, no package dependencies.
`default_nettype none

module trs_divider #(
   parameter int WIDTH    = 22,
   parameter int DIV_BITS = 12
) (
   input  wire logic                clock,
   input  wire logic                init,
   input  wire logic                step,
   input  wire logic [WIDTH-1:0]    dividend,
   input  wire logic [DIV_BITS-1:0] divisor,
   output logic      [WIDTH-1:0]    quotient
);

   logic [WIDTH-1:0]    quo_ff, quo_in;
   logic [DIV_BITS-1:0] rem_ff, rem_in;
   logic [DIV_BITS-1:0] den_ff, den_in;
   logic [DIV_BITS:0]   shifted;

   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (init) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (step) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = DIV_BITS'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_BITS-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/trs_datapath.sv
// Datapath: vertex sort and storage, edge products, two dividers, span assembly.
// Depends on trs_pkg and trs_divider.
`default_nettype none

module trs_datapath #(
   parameter int COORD_BITS = 11
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire trs_pkg::ctrl_cmd_type    cmd,
   output trs_pkg::ctrl_status_type      status,
   input  wire logic [COORD_BITS-1:0]    req_vertex_a_x,
   input  wire logic [COORD_BITS-1:0]    req_vertex_a_y,
   input  wire logic [COORD_BITS-1:0]    req_vertex_b_x,
   input  wire logic [COORD_BITS-1:0]    req_vertex_b_y,
   input  wire logic [COORD_BITS-1:0]    req_vertex_c_x,
   input  wire logic [COORD_BITS-1:0]    req_vertex_c_y,
   input  wire logic [23:0]              req_fill_color,
   output logic                          rsp_valid,
   output logic      [COORD_BITS-1:0]    rsp_span_row,
   output logic      [COORD_BITS-1:0]    rsp_span_left,
   output logic      [COORD_BITS-1:0]    rsp_span_right,
   output logic      [23:0]              rsp_span_color,
   output logic                          rsp_last_span
);

   localparam int C  = COORD_BITS;
   localparam int PW = 2 * C + 2;

   logic [C-1:0] x0_ff, y0_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic [C-1:0] x0_in, y0_in, x1_in, y1_in, x2_in, y2_in;
   logic [C-1:0] row_ff, row_in;
   logic         upper_ff, upper_in;
   logic         active_ff, active_in;
   logic [23:0]  color_ff, color_in;

   logic [C-1:0] sx0, sy0, sx1, sy1, sx2, sy2, tx, ty;

   always_comb begin
      tx  = '0; ty = '0;
      sx0 = req_vertex_a_x; sy0 = req_vertex_a_y;
      sx1 = req_vertex_b_x; sy1 = req_vertex_b_y;
      sx2 = req_vertex_c_x; sy2 = req_vertex_c_y;
      if (sy0 > sy1) begin
         tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
      end
      if (sy0 > sy2) begin
         tx = sx0; ty = sy0; sx0 = sx2; sy0 = sy2; sx2 = tx; sy2 = ty;
      end
      if (sy1 > sy2) begin
         tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
      end
   end

   // edge setup
   logic signed [C:0] d_long, d_half;
   logic [C-1:0]      n_long, n_half;
   logic [C:0]        h_long, h_half;
   logic [C-1:0]      base_half;

   always_comb begin
      d_long = $signed({1'b0, x2_ff}) - $signed({1'b0, x0_ff});
      n_long = row_ff - y0_ff;
      h_long = {1'b0, y2_ff} - {1'b0, y0_ff};
      if (!upper_ff) begin
         d_half    = $signed({1'b0, x1_ff}) - $signed({1'b0, x0_ff});
         n_half    = row_ff - y0_ff;
         h_half    = {1'b0, y1_ff} - {1'b0, y0_ff} + (C+1)'(1);
         base_half = x0_ff;
      end else begin
         d_half    = $signed({1'b0, x2_ff}) - $signed({1'b0, x1_ff});
         n_half    = row_ff - y1_ff;
         h_half    = {1'b0, y2_ff} - {1'b0, y1_ff} + (C+1)'(1);
         base_half = x1_ff;
      end
   end

   logic signed [PW-1:0] prod_long_ff, prod_half_ff;
   logic [C:0]           h_long_ff, h_half_ff;
   logic                 neg_long_ff, neg_half_ff;
   logic [2*C-1:0]       mag_long, mag_half;
   logic [2*C-1:0]       quo_long, quo_half;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         prod_long_ff <= PW'(d_long) * PW'($signed({1'b0, n_long}));
         prod_half_ff <= PW'(d_half) * PW'($signed({1'b0, n_half}));
         h_long_ff    <= h_long;
         h_half_ff    <= h_half;
      end
      if (cmd.init) begin
         neg_long_ff <= prod_long_ff[PW-1];
         neg_half_ff <= prod_half_ff[PW-1];
      end
   end

   always_comb begin
      mag_long = prod_long_ff[PW-1] ? (2*C)'(-prod_long_ff) : prod_long_ff[2*C-1:0];
      mag_half = prod_half_ff[PW-1] ? (2*C)'(-prod_half_ff) : prod_half_ff[2*C-1:0];
   end

   trs_divider #(.WIDTH(2 * C), .DIV_BITS(C + 1)) u_div_long (
      .clock    (clock),
      .init     (cmd.init),
      .step     (cmd.step),
      .dividend (mag_long),
      .divisor  (h_long_ff),
      .quotient (quo_long)
   );

   trs_divider #(.WIDTH(2 * C), .DIV_BITS(C + 1)) u_div_half (
      .clock    (clock),
      .init     (cmd.init),
      .step     (cmd.step),
      .dividend (mag_half),
      .divisor  (h_half_ff),
      .quotient (quo_half)
   );

   // quotient magnitude never exceeds the column range
   logic signed [C+1:0] q_long, q_half, edge_a, edge_b, left_w, right_w;
   logic                last_w;

   always_comb begin
      q_long  = neg_long_ff ? -$signed({2'b00, quo_long[C-1:0]})
                            :  $signed({2'b00, quo_long[C-1:0]});
      q_half  = neg_half_ff ? -$signed({2'b00, quo_half[C-1:0]})
                            :  $signed({2'b00, quo_half[C-1:0]});
      edge_a  = $signed({2'b00, x0_ff}) + q_long;
      edge_b  = $signed({2'b00, base_half}) + q_half;
      left_w  = (edge_a > edge_b) ? edge_b : edge_a;
      right_w = (edge_a > edge_b) ? edge_a : edge_b;
   end

   always_comb begin
      x0_in = x0_ff; y0_in = y0_ff; x1_in = x1_ff;
      y1_in = y1_ff; x2_in = x2_ff; y2_in = y2_ff;
      row_in    = row_ff;
      upper_in  = upper_ff;
      active_in = active_ff;
      color_in  = color_ff;
      last_w    = 1'b0;
      if (cmd.load) begin
         x0_in = sx0; y0_in = sy0; x1_in = sx1;
         y1_in = sy1; x2_in = sx2; y2_in = sy2;
         color_in  = req_fill_color;
         row_in    = sy0;
         upper_in  = 1'b0;
         active_in = (sy0 != sy2);
      end else if (cmd.finish) begin
         if (!upper_ff) begin
            if (row_ff >= y1_ff) upper_in = 1'b1;
            else                 row_in   = row_ff + C'(1);
         end else begin
            if (row_ff >= y2_ff) begin
               active_in = 1'b0;
               last_w    = 1'b1;
            end else begin
               row_in = row_ff + C'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x0_ff <= '0; y0_ff <= '0; x1_ff <= '0;
         y1_ff <= '0; x2_ff <= '0; y2_ff <= '0;
         row_ff    <= '0;
         upper_ff  <= 1'b0;
         active_ff <= 1'b0;
         color_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         x0_ff <= x0_in; y0_ff <= y0_in; x1_ff <= x1_in;
         y1_ff <= y1_in; x2_ff <= x2_in; y2_ff <= y2_in;
         row_ff    <= row_in;
         upper_ff  <= upper_in;
         active_ff <= active_in;
         color_ff  <= color_in;
         rsp_valid <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_span_row   <= row_ff;
         rsp_span_left  <= left_w[C-1:0];
         rsp_span_right <= right_w[C-1:0];
         rsp_span_color <= color_ff;
         rsp_last_span  <= last_w;
      end
   end

   assign status.active = active_ff;

endmodule

`default_nettype wire

FILE: rtl/trs_ctrl.sv
// Controller state machine: sequences load, multiply, divide and span emit.
// Depends on trs_pkg.
`default_nettype none

module trs_ctrl #(
   parameter int COORD_BITS = 11
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      req_cmd,
   input  wire trs_pkg::ctrl_status_type  status,
   output trs_pkg::ctrl_cmd_type          cmd,
   output logic                           busy
);

   localparam int DIV_STEPS = 2 * COORD_BITS;
   localparam int CNT_BITS  = $clog2(DIV_STEPS);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_INIT = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == trs_pkg::CMD_LOAD) begin
                  cmd.load = 1'b1;
               end else if (status.active) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.capture = 1'b1;
            state_in    = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/triangle_span_rasterizer_top.sv
// Top level of the triangle span rasterizer.
// Depends on trs_pkg, trs_ctrl, trs_datapath (and trs_divider below it).
//
// A transaction is taken when start is high and busy is low. A load (req_cmd = 0)
// sorts and stores the triangle and leaves busy low. A span request on a loaded
// triangle raises busy through a multiply state, a divider setup state, the
// division steps of the two restoring dividers that run side by side, and a
// state that forms the span. The span appears for one cycle with rsp_valid, in
// the first cycle in which busy is low again; the receiver must take it then,
// there is no backpressure. A span request with no triangle loaded is taken and
// produces nothing.
`default_nettype none

module triangle_span_rasterizer_top #(
   parameter int COORD_BITS = 11
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_cmd,
   input  wire logic [COORD_BITS-1:0] req_vertex_a_x,
   input  wire logic [COORD_BITS-1:0] req_vertex_a_y,
   input  wire logic [COORD_BITS-1:0] req_vertex_b_x,
   input  wire logic [COORD_BITS-1:0] req_vertex_b_y,
   input  wire logic [COORD_BITS-1:0] req_vertex_c_x,
   input  wire logic [COORD_BITS-1:0] req_vertex_c_y,
   input  wire logic [23:0]           req_fill_color,
   output logic                       rsp_valid,
   output logic      [COORD_BITS-1:0] rsp_span_row,
   output logic      [COORD_BITS-1:0] rsp_span_left,
   output logic      [COORD_BITS-1:0] rsp_span_right,
   output logic      [23:0]           rsp_span_color,
   output logic                       rsp_last_span
);

   trs_pkg::ctrl_cmd_type    cmd;
   trs_pkg::ctrl_status_type status;

   trs_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   trs_datapath #(.COORD_BITS(COORD_BITS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_vertex_a_x (req_vertex_a_x),
      .req_vertex_a_y (req_vertex_a_y),
      .req_vertex_b_x (req_vertex_b_x),
      .req_vertex_b_y (req_vertex_b_y),
      .req_vertex_c_x (req_vertex_c_x),
      .req_vertex_c_y (req_vertex_c_y),
      .req_fill_color (req_fill_color),
      .rsp_valid      (rsp_valid),
      .rsp_span_row   (rsp_span_row),
      .rsp_span_left  (rsp_span_left),
      .rsp_span_right (rsp_span_right),
      .rsp_span_color (rsp_span_color),
      .rsp_last_span  (rsp_last_span)
   );

endmodule

`default_nettype wire

FILE: rtl/trs_checker.sv
// Port-level checks for the triangle span rasterizer, bound to the top level.
// Depends on trs_pkg and triangle_span_rasterizer_top.
`default_nettype none

module trs_checker #(
   parameter int COORD_BITS = 11
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  req_cmd,
   input wire logic                  rsp_valid,
   input wire logic [COORD_BITS-1:0] rsp_span_left,
   input wire logic [COORD_BITS-1:0] rsp_span_right
);

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid high for more than one cycle");

   a_span_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_span_left <= rsp_span_right)
      else $error("span left edge beyond right edge");

   a_span_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("span emitted without a busy period");

   a_load_no_span: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cmd == trs_pkg::CMD_LOAD |=> !rsp_valid)
      else $error("span emitted right after a load");

endmodule

bind triangle_span_rasterizer_top trs_checker #(.COORD_BITS(COORD_BITS)) u_trs_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_cmd        (req_cmd),
   .rsp_valid      (rsp_valid),
   .rsp_span_left  (rsp_span_left),
   .rsp_span_right (rsp_span_right)
);

`default_nettype wire
